// ----- hw/rtl/cdq_pkg.sv -----
// Package for the circular deque: operation codes, status codes and field widths.
// No dependencies; imported by circular_deque and cdq_checker.
package cdq_pkg;

    localparam int DEPTH_DEF  = 8;   // default number of entries
    localparam int FUNC_W     = 2;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int FILL_W     = 4;
    localparam int S_TDATA_W  = 32;  // push_value
    localparam int M_TDATA_W  = 40;  // pop_value, fill_count, zero padding

    localparam logic [FUNC_W-1:0] OP_PUSH_REAR  = 2'd0;
    localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 2'd1;
    localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [FUNC_W-1:0] OP_POP_REAR   = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

endpackage

// ----- hw/rtl/circular_deque.sv -----
// Circular double-ended queue of signed 32-bit words held in one synchronous RAM.
// Depends on cdq_pkg (operation codes, status codes, widths).
//
//  channel | direction | tdata (low bit up)                     | tuser
//  --------+-----------+----------------------------------------+----------------
//  s_axis  | in        | push_value[31:0]                       | func[1:0]
//  m_axis  | out       | pop_value[31:0], fill_count[35:32], 0s | status[1:0]
//
// A push, a refused push and a refused pop are answered from the result register alone.
// A successful pop also goes through the entry RAM: the RAM registers its read
// data, and the result is registered in the cycle after that.
// Reset (aresetn low, synchronous) empties the deque and drops any pending result;
// the RAM is not cleared, since a pop only ever reads an entry that a push wrote.
// Input and output are parted by the output register: unless a pop waits for RAM data,
// a new transfer is taken if the result register is empty or drains in the same cycle.
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,   // [31:0] push_value
    input  logic [FUNC_W-1:0]      s_axis_tuser,   // [1:0] func
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [M_TDATA_W-1:0]   m_axis_tdata,   // [31:0] pop_value, [35:32] fill_count
    output logic [STATUS_W-1:0]    m_axis_tuser    // [1:0] status
);

    localparam int IW = $clog2(DEPTH);      // entry index width
    localparam int CW = $clog2(DEPTH + 1);  // entry count width, holds DEPTH itself
    localparam int SW = IW + 2;             // width of front + count sums
    localparam int EW = CW + FILL_W;        // count zero-extended before truncation

    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

    // Sequencer: idle, or waiting for the RAM read of a pop.
    typedef enum logic [1:0] {
        ST_IDLE     = 2'b01,
        ST_POP_WAIT = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [IW-1:0]        front_reg, front_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]   m_pop_reg, m_pop_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [FILL_W-1:0]    m_fill_reg, m_fill_next;

    // Entry RAM: one write port and one registered read port.
    logic [VALUE_W-1:0]   mem [DEPTH];
    logic [VALUE_W-1:0]   rd_data_reg;
    logic                 mem_we, mem_re;
    logic [IW-1:0]        wr_idx, rd_idx;

    logic                 accept, full, empty;
    logic [IW-1:0]        front_inc, front_dec, rear_free, rear_last;
    logic [SW-1:0]        sum_free, sum_last;
    logic [EW-1:0]        cnt_ext;

    assign s_axis_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);

    // Index arithmetic modulo DEPTH. Every sum stays below twice DEPTH, so one
    // compare and subtract wraps it.
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign sum_free  = SW'(front_reg) + SW'(count_reg);
    assign sum_last  = sum_free - 1'b1;
    assign rear_free = (sum_free >= DEPTH_S) ? IW'(sum_free - DEPTH_S) : IW'(sum_free);
    assign rear_last = (sum_last >= DEPTH_S) ? IW'(sum_last - DEPTH_S) : IW'(sum_last);

    always_comb begin
        state_next    = state_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_pop_next    = m_pop_reg;
        m_status_next = m_status_reg;
        m_fill_next   = m_fill_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        wr_idx        = rear_free;
        rd_idx        = front_reg;
        cnt_ext       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_status_next = STAT_DONE;
                    case (s_axis_tuser)
                        OP_PUSH_REAR: begin
                            if (full) begin
                                m_status_next = STAT_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                wr_idx     = rear_free;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_FRONT: begin
                            if (full) begin
                                m_status_next = STAT_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                wr_idx     = front_dec;
                                front_next = front_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (empty) begin
                                m_status_next = STAT_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                rd_idx     = front_reg;
                                front_next = front_inc;
                                count_next = count_reg - 1'b1;
                                state_next = ST_POP_WAIT;
                            end
                        end
                        default: begin
                            if (empty) begin
                                m_status_next = STAT_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                rd_idx     = rear_last;
                                count_next = count_reg - 1'b1;
                                state_next = ST_POP_WAIT;
                            end
                        end
                    endcase
                    cnt_ext     = EW'(count_next);
                    m_fill_next = cnt_ext[FILL_W-1:0];
                    // Results that need no RAM data go out right away.
                    if (state_next == ST_IDLE) begin
                        m_pop_next   = '0;
                        m_valid_next = 1'b1;
                    end
                end
            end
            ST_POP_WAIT: begin
                // The result register was emptied when the pop was accepted.
                m_pop_next   = rd_data_reg;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_pop_reg    <= m_pop_next;
        m_status_reg <= m_status_next;
        m_fill_reg   <= m_fill_next;
    end

    // Reads and writes never fall in the same cycle: a pop waits for its read
    // data before the next transfer is taken, so no forwarding is needed.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_idx] <= s_axis_tdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - VALUE_W - FILL_W)'(0), m_fill_reg, m_pop_reg};
    assign m_axis_tuser  = m_status_reg;

endmodule

// ----- hw/rtl/cdq_checker.sv -----
// Port-level checker for circular_deque, attached by the bind statement below.
// Depends on cdq_pkg (status codes, widths).
module cdq_checker
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata,
    input logic [STATUS_W-1:0]   m_axis_tuser
);

    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

    // A refused push can only happen with the deque full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == STAT_FULL)
        |-> m_axis_tdata[VALUE_W+FILL_W-1:VALUE_W] == FULL_FILL)
        else $error("refused push reports a count other than full");

    // A refused pop can only happen with the deque empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == STAT_EMPTY)
        |-> m_axis_tdata[VALUE_W+FILL_W-1:VALUE_W] == '0)
        else $error("refused pop reports a nonzero count");

    // A refused operation never returns a word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser != STAT_DONE)
        |-> m_axis_tdata[VALUE_W-1:0] == '0)
        else $error("refused operation returns a nonzero word");

    // A stalled result stays presented and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result dropped or changed");

endmodule

bind circular_deque cdq_checker #(.DEPTH(DEPTH)) u_cdq_checker (.*);
